// ===== hdl/tvhc_pkg.sv =====
// tvhc_pkg: shared types, command and status codes for the target value hit counter
// used by tvhc_cell and target_value_hit_counter_core; no dependencies
package tvhc_pkg;

  // default sizes
  localparam int DEPTH_DEF   = 64;
  localparam int COUNT_W_DEF = 32;

  // fixed field widths of the beats
  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 6;
  localparam int ST_W   = 3;
  localparam int LOAD_W = 7;
  localparam int OCNT_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RANGE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP     = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOMATCH = 3'd3;
  localparam logic [ST_W-1:0] ST_BADIDX  = 3'd4;

  // input beat
  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] limit_b;
    logic [IDX_W-1:0]        index;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic [OCNT_W-1:0]       entry_count;
    logic [LOAD_W-1:0]       entries_loaded;
  } out_beat_t;

  // command broadcast to every cell while a token walks the chain
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] key;
    logic [IDX_W-1:0] rd_idx;
  } ctl_t;

  // token handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] cur;
  } tok_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

endpackage

// ===== hdl/tvhc_cell.sv =====
// tvhc_cell: one table entry (target value and hit counter) of the chain
// acts on the token passing by and hands it to the next cell; depends on tvhc_pkg
module tvhc_cell import tvhc_pkg::*; #(
  parameter int CELL_ID     = 0,
  parameter int COUNT_WIDTH = COUNT_W_DEF,
  parameter int FILL_W      = $clog2(DEPTH_DEF + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctl_t                   ctl_i,
  input  logic [FILL_W-1:0]      fill_i,
  input  logic [FILL_W-1:0]      span_i,
  input  tok_t                   tok_i,
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  output tok_t                   tok_o,
  output logic [COUNT_WIDTH-1:0] cnt_o
);

  localparam logic [FILL_W-1:0] MY_ID   = FILL_W'(CELL_ID);
  localparam logic [FILL_W-1:0] MY_NEXT = FILL_W'(CELL_ID + 1);
  localparam bit                READABLE = (CELL_ID < (1 << IDX_W));
  localparam logic [IDX_W-1:0]  MY_IDX  = IDX_W'(CELL_ID);

  logic [VAL_W-1:0]       val_r, val_nxt;
  logic [COUNT_WIDTH-1:0] hits_r, hits_nxt, hits_inc;
  tok_t                   tok_r, tok_nxt;
  logic [COUNT_WIDTH-1:0] tcnt_r, tcnt_nxt;
  logic                   filled;

  assign filled   = (MY_ID < fill_i);
  assign hits_inc = (hits_r == {COUNT_WIDTH{1'b1}}) ? hits_r : hits_r + 1'b1;

  // per-cell action on the passing token
  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.cur = tok_i.cur + 32'd1;
    tcnt_nxt    = cnt_i;
    val_nxt     = val_r;
    hits_nxt    = hits_r;
    if (tok_i.vld) begin
      unique case (ctl_i.cmd)
        CMD_CLEAR: begin
          hits_nxt = '0;
        end
        CMD_ADD: begin
          if (!tok_i.hit) begin
            if (filled && (val_r == ctl_i.key)) begin
              tok_nxt.hit    = 1'b1;
              tok_nxt.status = ST_DUP;
              tok_nxt.idx    = MY_IDX;
              tok_nxt.val    = val_r;
              tcnt_nxt       = hits_r;
            end else if (MY_ID == fill_i) begin
              // first free slot, reached only after every filled entry missed
              val_nxt        = ctl_i.key;
              hits_nxt       = '0;
              tok_nxt.hit    = 1'b1;
              tok_nxt.status = ST_OK;
              tok_nxt.idx    = MY_IDX;
              tok_nxt.val    = ctl_i.key;
              tcnt_nxt       = '0;
            end
          end
        end
        CMD_RANGE: begin
          hits_nxt = '0;
          if (MY_ID < span_i) begin
            val_nxt = tok_i.cur;
          end
          if (MY_NEXT == span_i) begin
            tok_nxt.hit    = 1'b1;
            tok_nxt.status = ST_OK;
            tok_nxt.idx    = MY_IDX;
            tok_nxt.val    = tok_i.cur;
            tcnt_nxt       = '0;
          end
        end
        CMD_COUNT: begin
          if (filled && (val_r == ctl_i.key)) begin
            hits_nxt       = hits_inc;
            tok_nxt.hit    = 1'b1;
            tok_nxt.status = ST_OK;
            tok_nxt.idx    = MY_IDX;
            tok_nxt.val    = val_r;
            tcnt_nxt       = hits_inc;
          end
        end
        CMD_READ: begin
          if (READABLE && filled && (ctl_i.rd_idx == MY_IDX)) begin
            tok_nxt.hit    = 1'b1;
            tok_nxt.status = ST_OK;
            tok_nxt.idx    = MY_IDX;
            tok_nxt.val    = val_r;
            tcnt_nxt       = hits_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // counter and token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r    <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      hits_r <= hits_nxt;
      tok_r  <= tok_nxt;
      tcnt_r <= tcnt_nxt;
    end
  end

  // target value, undefined until written
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign tok_o = tok_r;
  assign cnt_o = tcnt_r;

endmodule

// ===== hdl/target_value_hit_counter_core.sv =====
// target_value_hit_counter_core: top level, command controller and the chain of entry cells
// depends on tvhc_pkg and tvhc_cell
//
// The table lives in a row of TABLE_DEPTH cells, one entry each. Every command beat launches a
// token that walks the row one cell per cycle; each cell matches, writes, counts or reads its own
// entry as the token passes, and the result is built from the token leaving the last cell. One
// beat is in flight at a time: a new one is taken only after launch, TABLE_DEPTH cell stages, result
// capture and output load of the last; a finished result waits in the result register, and blocks
// the next beat, until the output register is free. Reset needs no clearing pass.
module target_value_hit_counter_core import tvhc_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_DEPTH);

  state_t            state_r;
  ctl_t              ctl_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] span_r, span_nxt;
  logic              clip_r, clip_nxt;
  tok_t              lt_r, lt_nxt;
  out_beat_t         res_r, res_nxt;
  logic              out_valid_r;
  out_beat_t         out_data_r;

  tok_t                   tok_w [0:TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] cnt_w [0:TABLE_DEPTH];

  logic              accept;
  logic              move_out;
  logic              a_lt_b;
  logic [VAL_W-1:0]  lo, hi;
  logic [VAL_W:0]    diff;
  tok_t              tail;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign move_out  = (state_r == S_HOLD) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // range limits and clipped span of the beat
  always_comb begin
    a_lt_b   = (in_data.value < in_data.limit_b);
    lo       = a_lt_b ? in_data.value : in_data.limit_b;
    hi       = a_lt_b ? in_data.limit_b : in_data.value;
    diff     = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
    clip_nxt = (diff >= (VAL_W+1)'(TABLE_DEPTH));
    span_nxt = clip_nxt ? FILL_MAX : FILL_W'(diff + 1'b1);
  end

  // launch token
  always_comb begin
    lt_nxt        = '0;
    lt_nxt.vld    = accept;
    lt_nxt.status = ST_OK;
    lt_nxt.cur    = lo;
  end

  // cell row
  assign tok_w[0] = lt_r;
  assign cnt_w[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tvhc_cell #(
      .CELL_ID    (i),
      .COUNT_WIDTH(COUNT_WIDTH),
      .FILL_W     (FILL_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_r),
      .fill_i(fill_r),
      .span_i(span_r),
      .tok_i (tok_w[i]),
      .cnt_i (cnt_w[i]),
      .tok_o (tok_w[i+1]),
      .cnt_o (cnt_w[i+1])
    );
  end

  assign tail = tok_w[TABLE_DEPTH];

  // result from the token leaving the last cell
  always_comb begin
    fill_nxt = fill_r;
    res_nxt  = '0;
    res_nxt.status = ST_OK;
    unique case (ctl_r.cmd)
      CMD_CLEAR: begin
        fill_nxt = '0;
      end
      CMD_ADD: begin
        if (tail.hit) begin
          res_nxt.status      = tail.status;
          res_nxt.entry_index = tail.idx;
          res_nxt.entry_value = tail.val;
          res_nxt.entry_count = OCNT_W'(cnt_w[TABLE_DEPTH]);
          if (tail.status == ST_OK) begin
            fill_nxt = fill_r + 1'b1;
          end
        end else begin
          res_nxt.status = ST_FULL;
        end
      end
      CMD_RANGE: begin
        fill_nxt            = span_r;
        res_nxt.status      = clip_r ? ST_FULL : ST_OK;
        res_nxt.entry_index = tail.idx;
        res_nxt.entry_value = tail.val;
      end
      CMD_COUNT: begin
        if (tail.hit) begin
          res_nxt.entry_index = tail.idx;
          res_nxt.entry_value = tail.val;
          res_nxt.entry_count = OCNT_W'(cnt_w[TABLE_DEPTH]);
        end else begin
          res_nxt.status = ST_NOMATCH;
        end
      end
      CMD_READ: begin
        if (tail.hit) begin
          res_nxt.entry_index = tail.idx;
          res_nxt.entry_value = tail.val;
          res_nxt.entry_count = OCNT_W'(cnt_w[TABLE_DEPTH]);
        end else begin
          res_nxt.status      = ST_BADIDX;
          res_nxt.entry_index = ctl_r.rd_idx;
        end
      end
      default: begin
      end
    endcase
    res_nxt.entries_loaded = LOAD_W'(fill_nxt);
  end

  // controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      lt_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            ctl_r.cmd    <= in_data.command;
            ctl_r.key    <= in_data.value;
            ctl_r.rd_idx <= in_data.index;
            span_r       <= span_nxt;
            clip_r       <= clip_nxt;
            state_r      <= S_RUN;
          end
        end
        S_RUN: begin
          if (tail.vld) begin
            res_r   <= res_nxt;
            fill_r  <= fill_nxt;
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (move_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // output register
      if (move_out) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("entry count beyond table depth");

  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> state_r == S_RUN)
    else $error("token left the row outside a command");

  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !lt_r.vld && !tail.vld)
    else $error("token in flight while idle");

  a_hold_moves: assert property (@(posedge clk) disable iff (!rst_n)
    move_out |=> out_valid_r && state_r == S_IDLE)
    else $error("held result not loaded into output");

  a_launch_once: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> lt_r.vld && state_r == S_RUN)
    else $error("accepted beat did not launch a token");
`endif

endmodule
